/* rtl/elevator_order_queue_core_defines.svh */
// Assertion macros for the elevator order queue core.
`ifndef ELEVATOR_ORDER_QUEUE_CORE_DEFINES_SVH
`define ELEVATOR_ORDER_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define EOQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define EOQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/eoq_pkg.sv */
// Shared types and constants of the elevator order queue.
`default_nettype none

package eoq_pkg;

  localparam int QueueDepth = 16;
  localparam int FloorCount = 4;

  localparam logic [1:0] DirCab = 2'd1;
  localparam logic [1:0] DirUp  = 2'd2;

  typedef enum logic [1:0] {
    ReqAddBack  = 2'd0,
    ReqAddFront = 2'd1,
    ReqService  = 2'd2,
    ReqClear    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StatAdded = 2'd0,
    StatDup   = 2'd1,
    StatFull  = 2'd2,
    StatNone  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] dir;
    logic [3:0] floor;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/eoq_store.sv */
// Order store: one write port, one registered read port.
`default_nettype none

module eoq_store #(
  parameter int Depth = eoq_pkg::QueueDepth,
  parameter int AW    = $clog2(Depth)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire eoq_pkg::entry_t wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output eoq_pkg::entry_t      rdata_o
);

  eoq_pkg::entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/elevator_order_queue_core.sv */
// Top level of the elevator order queue: request sequencer around the order store.
`default_nettype none

`include "elevator_order_queue_core_defines.svh"

// One request at a time, one result item per request. The store has one read
// and one write port, so each pass walks it one entry a cycle. Clear, an ignored
// add and an add refused on the head floor go straight to the done state; an add
// to an empty queue goes straight to the write; a back add scans, then writes; a
// front add scans, shifts up, then writes; an add refused as full ends after the
// scan; a serviced floor compacts (straight to done on an empty queue); a
// duplicate found during the scan ends it early. A finished result waits in the
// done state for as long as the previous one has not been taken.
// s_axis_tready_o is high only between requests. No clearing pass after reset.
module elevator_order_queue_core #(
  parameter int QUEUE_DEPTH = eoq_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // order_floor[3:0], order_direction[5:4]
  input  wire logic [1:0]  s_axis_tuser_i,  // req_type[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // add_status[1:0], removed_count[6:2], order_count[11:7], head_valid[12],
  // head_floor[16:13], head_direction[18:17]
  output logic [23:0]      m_axis_tdata_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StScan    = 6'b000010,
    StShift   = 6'b000100,
    StWrite   = 6'b001000,
    StCompact = 6'b010000,
    StDone    = 6'b100000
  } st_e;

  st_e               state_q, state_d;
  eoq_pkg::req_e     req_q, req_d;
  eoq_pkg::entry_t   ent_q, ent_d;
  eoq_pkg::entry_t   head_q, head_d;
  eoq_pkg::status_e  status_q, status_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     removed_q, removed_d;
  logic [CW-1:0]     rp_q, rp_d;
  logic [CW-1:0]     wp_q, wp_d;
  logic [CW-1:0]     rp_m1;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     ri_q, ri_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;
  logic              m_valid_q, m_valid_d;
  logic [23:0]       m_data_q, m_data_d;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  eoq_pkg::entry_t   mem_wdata, mem_rdata;

  eoq_pkg::req_e     in_req;
  eoq_pkg::entry_t   in_ent;
  logic              in_ok;
  logic              s_acc;
  logic              out_free;
  logic              rd_match;
  logic              rd_dup;
  logic              out_empty;

  eoq_store #(
    .Depth (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_req          = eoq_pkg::req_e'(s_axis_tuser_i);
  assign in_ent.floor    = s_axis_tdata_i[3:0];
  assign in_ent.dir      = s_axis_tdata_i[5:4];
  assign in_ok           = ({1'b0, in_ent.floor} < 5'(eoq_pkg::FloorCount)) &&
                           (in_ent.dir <= eoq_pkg::DirUp);
  assign s_axis_tready_o = (state_q == StIdle);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign rd_match        = (mem_rdata.floor == ent_q.floor);
  assign rd_dup          = rd_match && ((mem_rdata.dir == eoq_pkg::DirCab) ||
                                        (mem_rdata.dir == ent_q.dir));
  assign rp_m1           = rp_q - 1'b1;
  assign out_empty       = (count_q == '0);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    ent_d     = ent_q;
    head_d    = head_q;
    status_d  = status_q;
    count_d   = count_q;
    removed_d = removed_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    rd_vld_d  = 1'b0;
    ri_d      = ri_q;
    wr_addr_d = wr_addr_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = ent_q;
    mem_re    = 1'b0;
    mem_raddr = rp_q[AW-1:0];

    case (state_q)
      StIdle: begin
        if (s_acc) begin
          req_d     = in_req;
          ent_d     = in_ent;
          status_d  = eoq_pkg::StatNone;
          removed_d = '0;
          rp_d      = '0;
          wp_d      = '0;
          wr_addr_d = '0;
          case (in_req)
            eoq_pkg::ReqAddBack, eoq_pkg::ReqAddFront: begin
              if (!in_ok) begin
                state_d = StDone;
              end else if (count_q == '0) begin
                state_d = StWrite;
              end else if (head_q.floor == in_ent.floor) begin
                status_d = eoq_pkg::StatDup;
                state_d  = StDone;
              end else begin
                state_d = StScan;
              end
            end
            eoq_pkg::ReqService: begin
              state_d = (count_q == '0) ? StDone : StCompact;
            end
            default: begin
              removed_d = count_q;
              count_d   = '0;
              state_d   = StDone;
            end
          endcase
        end
      end

      StScan: begin
        if (rp_q != count_q) begin
          mem_re   = 1'b1;
          rp_d     = rp_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q && rd_dup) begin
          status_d = eoq_pkg::StatDup;
          state_d  = StDone;
        end else if (!rd_vld_q && (rp_q == count_q)) begin
          if (count_q == DepthC) begin
            status_d = eoq_pkg::StatFull;
            state_d  = StDone;
          end else if (req_q == eoq_pkg::ReqAddBack) begin
            wr_addr_d = count_q[AW-1:0];
            state_d   = StWrite;
          end else begin
            rp_d    = count_q;
            state_d = StShift;
          end
        end
      end

      StShift: begin
        if (rp_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = rp_m1[AW-1:0];
          rp_d      = rp_m1;
          ri_d      = rp_m1[AW-1:0];
          rd_vld_d  = 1'b1;
        end
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(ri_q + 1'b1);
          mem_wdata = mem_rdata;
        end else if (rp_q == '0) begin
          wr_addr_d = '0;
          state_d   = StWrite;
        end
      end

      StWrite: begin
        mem_we    = 1'b1;
        mem_waddr = wr_addr_q;
        mem_wdata = ent_q;
        count_d   = count_q + 1'b1;
        status_d  = eoq_pkg::StatAdded;
        if ((req_q == eoq_pkg::ReqAddFront) || (count_q == '0)) begin
          head_d = ent_q;
        end
        state_d = StDone;
      end

      StCompact: begin
        if (rp_q != count_q) begin
          mem_re   = 1'b1;
          rp_d     = rp_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          if (rd_match) begin
            removed_d = removed_q + 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wp_q[AW-1:0];
            mem_wdata = mem_rdata;
            wp_d      = wp_q + 1'b1;
            if (wp_q == '0) begin
              head_d = mem_rdata;
            end
          end
        end else if (rp_q == count_q) begin
          count_d = wp_q;
          state_d = StDone;
        end
      end

      StDone: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'd0,
                       out_empty ? 2'd0 : head_q.dir,
                       out_empty ? 4'd0 : head_q.floor,
                       !out_empty,
                       5'(count_q),
                       5'(removed_q),
                       status_q};
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      rp_q      <= '0;
      wp_q      <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    ent_q     <= ent_d;
    head_q    <= head_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    ri_q      <= ri_d;
    wr_addr_q <= wr_addr_d;
    m_data_q  <= m_data_d;
  end

  `EOQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= DepthC, "order count above depth")
  `EOQ_ASSERT_NXT(a_busy_after_accept, s_acc, state_q != StIdle, "idle after accept")
  `EOQ_ASSERT_NXT(a_result_loaded, (state_q == StDone) && out_free, m_valid_q,
                  "result not presented")
  `EOQ_ASSERT_IMP(a_write_in_range, mem_we && (state_q == StWrite), count_q < DepthC,
                  "write to a full store")

endmodule

`default_nettype wire
